/* hdl/bmhq_pkg.sv */
// Shared types and constants for the binary max-heap queue.
`default_nettype none
package bmhq_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 11;
  // index fields sized for the largest supported capacity (65536)
  localparam int IDX_W   = 17;
  localparam int STEP_W  = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // token kinds walking down the level chain
  localparam logic [1:0] TK_INS   = 2'd0;
  localparam logic [1:0] TK_FETCH = 2'd1;
  localparam logic [1:0] TK_DEL   = 2'd2;

  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic                     removed_valid;
    logic [1:0]               status;
    logic [COUNT_W-1:0]       count;
    logic                     empty_res;
  } rsp_t;

  typedef struct packed {
    logic                     valid;
    logic [1:0]               kind;
    logic                     done;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] top;
    logic [IDX_W-1:0]         idx;
    logic [IDX_W-1:0]         target;
    logic [STEP_W-1:0]        steps;
  } tok_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } probe_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] right;
  } kids_t;

endpackage
`default_nettype wire

/* hdl/bmhq_ram.sv */
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic      [WIDTH-1:0]                     rdata_a,
  output logic      [WIDTH-1:0]                     rdata_b
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

/* hdl/bmhq_cell.sv */
// One heap level: its slot RAM, the per-level compare and the hand-off to the next level.
`default_nettype none
module bmhq_cell import bmhq_pkg::*; #(
  parameter int   LEVEL = 0,
  parameter logic LAST  = 1'b0
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire tok_t   tok_in,
  output tok_t        tok_out,
  input  wire probe_t probe_in,
  output probe_t      probe_out,
  input  wire kids_t  kids_in,
  output kids_t       kids_out
);

  localparam int DEPTH = 1 << LEVEL;
  localparam int AW    = (LEVEL > 0) ? LEVEL : 1;
  localparam logic [IDX_W-1:0] OFF_MASK = IDX_W'((1 << LEVEL) - 1);
  localparam logic [AW-1:0]    ODD      = (LEVEL > 0) ? AW'(1) : '0;
  localparam logic             HAS_KIDS = !LAST;

  tok_t                     hold;
  tok_t                     out;
  tok_t                     nxt;
  logic                     busy;
  logic [AW-1:0]            own_off;
  logic [AW-1:0]            probe_off;
  logic [AW-1:0]            ra;
  logic [AW-1:0]            rb;
  logic [AW-1:0]            wa;
  logic                     we;
  logic signed [DATA_W-1:0] wd;
  logic signed [DATA_W-1:0] rd_a;
  logic signed [DATA_W-1:0] rd_b;
  logic [STEP_W-1:0]        dm1;
  logic [IDX_W:0]           cl;
  logic [IDX_W:0]           cr;
  logic [IDX_W:0]           lim;
  logic                     lv;
  logic                     rv;
  logic                     pick_r;
  logic signed [DATA_W-1:0] cv;
  logic [IDX_W:0]           cidx;

  assign own_off   = AW'(tok_in.idx & OFF_MASK);
  assign probe_off = AW'(probe_in.idx & OFF_MASK);
  assign ra        = probe_in.valid ? probe_off : own_off;
  assign rb        = probe_off | ODD;

  // parent asks for the two children of its hole
  assign probe_out.valid = HAS_KIDS && tok_in.valid && !tok_in.done && (tok_in.kind == TK_DEL);
  assign probe_out.idx   = tok_in.idx << 1;

  assign kids_out.left  = rd_a;
  assign kids_out.right = rd_b;

  assign tok_out = out;

  bmhq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (wa),
    .wdata   (wd),
    .raddr_a (ra),
    .raddr_b (rb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_comb begin
    nxt    = hold;
    we     = 1'b0;
    wa     = AW'(hold.idx & OFF_MASK);
    wd     = hold.key;
    dm1    = hold.steps - STEP_W'(1);
    cl     = {hold.idx, 1'b0};
    cr     = {hold.idx, 1'b1};
    lim    = {1'b0, hold.target};
    lv     = HAS_KIDS && (cl <= lim);
    rv     = HAS_KIDS && (cr <= lim);
    pick_r = rv && !(kids_in.left > kids_in.right);
    cv     = pick_r ? kids_in.right : kids_in.left;
    cidx   = pick_r ? cr : cl;
    case (hold.kind)
      TK_INS: begin
        if (hold.steps == '0) begin
          we       = busy;
          nxt.done = 1'b1;
        end else begin
          if (hold.key > rd_a) begin
            we      = busy;
            nxt.key = rd_a;
          end
          nxt.idx   = {hold.idx[IDX_W-2:0], hold.target[dm1]};
          nxt.steps = dm1;
        end
      end
      TK_FETCH: begin
        if (LEVEL == 0) begin
          nxt.top = rd_a;
        end
        if (hold.steps == '0) begin
          nxt.key  = rd_a;
          nxt.done = 1'b1;
        end else begin
          nxt.idx   = {hold.idx[IDX_W-2:0], hold.target[dm1]};
          nxt.steps = dm1;
        end
      end
      TK_DEL: begin
        we = busy;
        if (lv && (cv > hold.key)) begin
          wd      = cv;
          nxt.idx = IDX_W'(cidx);
        end else begin
          nxt.done = 1'b1;
        end
      end
      default: begin
        nxt.done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      hold <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out.valid <= 1'b0;
    end else begin
      busy <= tok_in.valid && !tok_in.done;
      if (tok_in.valid && tok_in.done) begin
        out <= tok_in;
      end else if (busy) begin
        out <= nxt;
      end else begin
        out.valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/binary_max_heap_queue_core.sv */
// Binary max-heap priority queue: controller and chain of per-level cells.
// One request at a time; L = clog2(CAPACITY+1) levels (11 at 1024).
// Insert: one registered RAM read and compare per level on the path.
// Removal: a pass to fetch the last slot, then a sift-down pass.
// Failed removal or insert answers without a walk; result register frees the input side.
// Synchronous reset empties the heap; slot RAMs are not cleared.
`default_nettype none
module binary_max_heap_queue_core import bmhq_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int LEVELS = $clog2(CAPACITY + 1);
  localparam int CW     = LEVELS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_SIFT  = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;

  logic [2:0]        state;
  logic [CW-1:0]     count;
  logic [CW-1:0]     path_src;
  logic [STEP_W-1:0] lev;
  logic              accept;
  logic              full;
  logic              empty;
  logic              rsp_load;
  tok_t              head;
  tok_t              tail;
  rsp_t              staged;
  rsp_t              rsp_q;
  logic              rsp_q_valid;

  tok_t   chain_tok [0:LEVELS];
  probe_t probes    [0:LEVELS];
  kids_t  kids      [0:LEVELS];

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign rsp_load  = (state == S_DONE) && (!rsp_q_valid || !rsp_stall);
  assign rsp_valid = rsp_q_valid;
  assign rsp       = rsp_q;

  assign chain_tok[0] = head;
  assign probes[0]    = '0;
  assign kids[LEVELS] = '0;
  assign tail         = chain_tok[LEVELS];

  genvar g;
  generate
    for (g = 0; g < LEVELS; g++) begin : g_level
      bmhq_cell #(
        .LEVEL (g),
        .LAST  (g == LEVELS - 1)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .tok_in    (chain_tok[g]),
        .tok_out   (chain_tok[g+1]),
        .probe_in  (probes[g]),
        .probe_out (probes[g+1]),
        .kids_in   (kids[g+1]),
        .kids_out  (kids[g])
      );
    end
  endgenerate

  // level of the slot on the path: top set bit
  assign path_src = (req.op == OP_INSERT) ? count + CW'(1) : count;

  always_comb begin
    lev = '0;
    for (int b = 0; b < CW; b++) begin
      if (path_src[b]) begin
        lev = STEP_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      head.valid  <= 1'b0;
      rsp_q_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            staged.removed_value <= '0;
            staged.removed_valid <= 1'b0;
            if (req.op == OP_INSERT) begin
              if (full) begin
                staged.status    <= ST_FULL;
                staged.count     <= COUNT_W'(count);
                staged.empty_res <= empty;
                state            <= S_DONE;
              end else begin
                head <= '{valid: 1'b1, kind: TK_INS, done: 1'b0, key: req.value,
                          top: '0, idx: IDX_W'(1), target: IDX_W'(path_src), steps: lev};
                count            <= count + CW'(1);
                staged.status    <= ST_OK;
                staged.count     <= COUNT_W'(count + CW'(1));
                staged.empty_res <= 1'b0;
                state            <= S_SIFT;
              end
            end else begin
              if (empty) begin
                staged.status    <= ST_EMPTY;
                staged.count     <= '0;
                staged.empty_res <= 1'b1;
                state            <= S_DONE;
              end else begin
                head <= '{valid: 1'b1, kind: TK_FETCH, done: 1'b0, key: '0,
                          top: '0, idx: IDX_W'(1), target: IDX_W'(path_src), steps: lev};
                count            <= count - CW'(1);
                staged.status    <= ST_OK;
                staged.count     <= COUNT_W'(count - CW'(1));
                staged.empty_res <= (count == CW'(1));
                state            <= S_FETCH;
              end
            end
          end
        end
        S_FETCH: begin
          if (tail.valid) begin
            staged.removed_value <= tail.top;
            staged.removed_valid <= 1'b1;
            head <= '{valid: 1'b1, kind: TK_DEL, done: 1'b0, key: tail.key,
                      top: '0, idx: IDX_W'(1), target: IDX_W'(count), steps: '0};
            state <= S_SIFT;
          end else begin
            head.valid <= 1'b0;
          end
        end
        S_SIFT: begin
          head.valid <= 1'b0;
          if (tail.valid) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (rsp_load) begin
        rsp_q       <= staged;
        rsp_q_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_q_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_tail_when_busy: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> (state == S_FETCH || state == S_SIFT))
    else $error("token left the chain with no walk in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted beat did not start work");

  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.removed_valid) |-> (rsp.status == ST_OK))
    else $error("removed value flagged with error status");

endmodule
`default_nettype wire

/* dv/bmhq_checker.sv */
// Checker for the max-heap queue: tracks the heap, predicts each result and compares it.
module bmhq_checker import bmhq_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   mismatches,
  output int   outstanding
);

  logic signed [DATA_W-1:0] heap_mem [1:CAPACITY];
  int unsigned held = 0;
  rsp_t awaited_rsp [$];
  int fail_count = 0;
  int waiting = 0;

  assign mismatches  = fail_count;
  assign outstanding = waiting;

  function automatic rsp_t heap_apply(input req_t r);
    rsp_t o;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] last;
    int unsigned pos;
    int unsigned up;
    int unsigned child;
    o = '0;
    o.status = ST_OK;
    if (r.op == OP_INSERT) begin
      if (held >= CAPACITY) begin
        o.status = ST_FULL;
      end else begin
        key = r.value;
        pos = held + 1;
        while (pos != 1) begin
          up = pos / 2;
          if (heap_mem[up] < key) begin
            heap_mem[pos] = heap_mem[up];
            pos = up;
          end else begin
            break;
          end
        end
        heap_mem[pos] = key;
        held++;
      end
    end else if (held == 0) begin
      o.status = ST_EMPTY;
    end else begin
      o.removed_value = heap_mem[1];
      o.removed_valid = 1'b1;
      last = heap_mem[held];
      pos = 1;
      forever begin
        child = pos * 2;
        if (child > held) break;
        // ties go right
        if (child < held && !(heap_mem[child] > heap_mem[child + 1])) child++;
        if (last >= heap_mem[child]) break;
        heap_mem[pos] = heap_mem[child];
        pos = child;
      end
      heap_mem[pos] = last;
      held--;
    end
    o.count     = held[COUNT_W-1:0];
    o.empty_res = (held == 0);
    return o;
  endfunction

  task automatic flag(input string field, input longint want_v, input longint got_v);
    $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsp.size() == 0) begin
          $display("%0t: result expected none, got %p", $time, rsp);
          fail_count++;
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.removed_value !== want.removed_value)
            flag("removed_value", want.removed_value, rsp.removed_value);
          if (rsp.removed_valid !== want.removed_valid)
            flag("removed_valid", want.removed_valid, rsp.removed_valid);
          if (rsp.status !== want.status) flag("status", want.status, rsp.status);
          if (rsp.count !== want.count) flag("count", want.count, rsp.count);
          if (rsp.empty_res !== want.empty_res) flag("empty_res", want.empty_res, rsp.empty_res);
        end
      end
      if (req_valid && !req_stall) awaited_rsp.push_back(heap_apply(req));
      waiting = awaited_rsp.size();
    end
  end

endmodule

/* dv/testbench.sv */
// Top of the max-heap queue testbench: clock, reset, request stimulus and verdict.
module testbench import bmhq_pkg::*; ();

  localparam int HEAP_CAP = 1024;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int mismatches;
  int outstanding;
  int send_gap_pct = 14;
  int stall_pct = 68;
  int insert_pct = 50;

  binary_max_heap_queue_core #(.CAPACITY(HEAP_CAP)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  bmhq_checker #(.CAPACITY(HEAP_CAP)) i_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  always @(negedge clk) rsp_stall <= ($urandom_range(99) < stall_pct);

  initial begin
    #20000000;
    $display("testbench failed");
    $finish;
  end

  task automatic send_beat(input logic op, input logic signed [DATA_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{op: op, value: v};
    do @(posedge clk); while (req_stall);
  endtask

  task automatic insert_value(input logic signed [DATA_W-1:0] v);
    send_beat(OP_INSERT, v);
  endtask

  task automatic remove_max();
    send_beat(OP_REMOVE, $urandom);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return $signed($urandom_range(15)) - 8;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed: empty removal, extremes, duplicates, bit patterns
    remove_max();
    insert_value(32'sh7fffffff);
    insert_value(32'sh80000000);
    insert_value(0);
    insert_value(-1);
    insert_value(5);
    insert_value(5);
    insert_value(5);
    insert_value(1);
    repeat (8) remove_max();
    remove_max();
    insert_value(32'sh55555555);
    insert_value(32'shaaaaaaaa);
    remove_max();
    remove_max();
    hold_until_drained();

    for (int i = 0; i < 850; i++) begin
      if (i == 284) begin
        hold_until_drained();
        send_gap_pct = 68;
        stall_pct = 14;
      end else if (i == 568) begin
        hold_until_drained();
        send_gap_pct = 0;
        stall_pct = 0;
      end
      if (i % 40 == 0) insert_pct = 25 * $urandom_range(1, 3);
      if ($urandom_range(99) < insert_pct) insert_value(pick_value());
      else remove_max();
    end

    @(negedge clk);
    req_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
